// ----- rtl/core/dpi_pkg.sv -----
// ----------------------------------------------------------------------------
// dpi_pkg
// Types and codes shared by the data-processing-immediate execute block.
// ----------------------------------------------------------------------------
`default_nettype none

package dpi_pkg;

	localparam int XLEN          = 64;
	localparam int NUM_REGS      = 32;
	localparam int REG_IDX_W     = $clog2(NUM_REGS);
	localparam int DEPTH_DEFAULT = 2;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNIMP = 2'd1;
	localparam logic [1:0] ST_UNDEF = 2'd2;

	// Instruction kinds as classified by the front end
	localparam logic [1:0] KIND_ADDSUB = 2'd0;
	localparam logic [1:0] KIND_LOGIC  = 2'd1;
	localparam logic [1:0] KIND_UNIMP  = 2'd2;
	localparam logic [1:0] KIND_UNDEF  = 2'd3;

	// Logical opc codes
	localparam logic [1:0] OPC_AND  = 2'd0;
	localparam logic [1:0] OPC_ORR  = 2'd1;
	localparam logic [1:0] OPC_EOR  = 2'd2;
	localparam logic [1:0] OPC_ANDS = 2'd3;

	typedef struct packed {
		logic [1:0]           kind;
		logic                 sf;
		logic [1:0]           opc;   // add/sub: {sub, setflag}; logical: opc
		logic [REG_IDX_W-1:0] rd;
		logic [REG_IDX_W-1:0] rn;
		logic [XLEN-1:0]      imm;   // add/sub immediate or logical mask
	} dec_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [REG_IDX_W-1:0] rd;
		logic [XLEN-1:0]      value;
		logic [3:0]           nzcv;
	} res_t;

endpackage

`default_nettype wire

// ----- rtl/core/dpi_queue.sv -----
// ----------------------------------------------------------------------------
// dpi_queue
// Small synchronous queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module dpi_queue #(
	parameter type item_t = logic,
	parameter int  DEPTH  = 2
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  item_t      push_data,
	output logic       full,
	input  wire logic  pop,
	output item_t      pop_data,
	output logic       empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t             mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/dpi_front.sv -----
// ----------------------------------------------------------------------------
// dpi_front
// Classifies an instruction word and builds its immediate or bit mask.
// ----------------------------------------------------------------------------
`default_nettype none

module dpi_front (
	input  wire logic [31:0] instr,
	output dpi_pkg::dec_t    dec
);

	import dpi_pkg::*;

	localparam logic [2:0] OP0_ADDSUB = 3'b010;
	localparam logic [2:0] OP0_LOGIC  = 3'b100;

	logic [2:0]      op0;
	logic [5:0]      imms;
	logic [5:0]      immr;
	logic            n_bit;
	logic [6:0]      len_vec;
	logic [5:0]      levels;
	logic [5:0]      s_val;
	logic [5:0]      r_val;
	logic [XLEN-1:0] mask;
	logic [XLEN-1:0] addsub_imm;
	logic            mask_bad;

	assign op0     = instr[25:23];
	assign imms    = instr[15:10];
	assign immr    = instr[21:16];
	assign n_bit   = instr[22];
	assign len_vec = {n_bit, ~imms};

	// levels = ones(len), len being the top set bit of len_vec
	always_comb begin
		for (int k = 0; k < 6; k++) begin
			levels[k] = |(len_vec >> (k + 1));
		end
	end

	assign s_val = imms & levels;
	assign r_val = immr & levels;

	// Rotated element, replicated: bit i is set when its rotated slot is <= s
	always_comb begin
		for (int i = 0; i < XLEN; i++) begin
			mask[i] = (((6'(i) & levels) + r_val) & levels) <= s_val;
		end
	end

	assign mask_bad   = (len_vec[6:1] == '0) || (s_val == levels) || (!instr[31] && n_bit);
	assign addsub_imm = instr[22] ? XLEN'({instr[21:10], 12'd0}) : XLEN'(instr[21:10]);

	always_comb begin
		dec.sf  = instr[31];
		dec.opc = instr[30:29];
		dec.rd  = instr[4:0];
		dec.rn  = instr[9:5];
		dec.imm = '0;
		unique case (op0)
			OP0_ADDSUB: begin
				dec.kind = KIND_ADDSUB;
				dec.imm  = addsub_imm;
			end
			OP0_LOGIC: begin
				dec.kind = mask_bad ? KIND_UNDEF : KIND_LOGIC;
				dec.imm  = mask;
			end
			default: begin
				dec.kind = KIND_UNIMP;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/dpi_back.sv -----
// ----------------------------------------------------------------------------
// dpi_back
// Executes decoded items against the register file and the NZCV flags.
// ----------------------------------------------------------------------------
`default_nettype none

module dpi_back (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  dpi_pkg::dec_t  dec,
	input  wire logic      dec_empty,
	output logic           dec_pop,
	output dpi_pkg::res_t  res,
	input  wire logic      res_full,
	output logic           res_push
);

	import dpi_pkg::*;

	logic [XLEN-1:0] gpr_q [NUM_REGS];
	logic [3:0]      nzcv_q;

	logic            fire;
	logic [XLEN-1:0] op_a;
	logic [XLEN-1:0] op_b;
	logic            is_sub;
	logic            set_flags;
	logic [XLEN:0]   sum64;
	logic [32:0]     sum32;
	logic [XLEN-1:0] as_res;
	logic [XLEN-1:0] lg_res;
	logic            as_c;
	logic            as_v;
	logic [XLEN-1:0] value;
	logic [3:0]      nzcv_next;
	logic            wr_en;
	logic            top_bit;

	assign fire     = !dec_empty && !res_full;
	assign dec_pop  = fire;
	assign res_push = fire;

	assign op_a   = gpr_q[dec.rn];
	assign is_sub = dec.opc[1];
	assign op_b   = is_sub ? ~dec.imm : dec.imm;

	assign sum64 = {1'b0, op_a} + {1'b0, op_b} + (XLEN + 1)'(is_sub);
	assign sum32 = {1'b0, op_a[31:0]} + {1'b0, op_b[31:0]} + 33'(is_sub);

	always_comb begin
		if (dec.sf) begin
			as_res = sum64[XLEN-1:0];
			as_c   = sum64[XLEN];
			as_v   = (op_a[XLEN-1] ^ sum64[XLEN-1]) & (op_b[XLEN-1] ^ sum64[XLEN-1]);
		end else begin
			as_res = {32'd0, sum32[31:0]};
			as_c   = sum32[32];
			as_v   = (op_a[31] ^ sum32[31]) & (op_b[31] ^ sum32[31]);
		end
	end

	always_comb begin
		case (dec.opc)
			OPC_ORR: lg_res = op_a | dec.imm;
			OPC_EOR: lg_res = op_a ^ dec.imm;
			default: lg_res = op_a & dec.imm;
		endcase
		if (!dec.sf) begin
			lg_res[XLEN-1:32] = '0;
		end
	end

	always_comb begin
		value     = '0;
		wr_en     = 1'b0;
		set_flags = 1'b0;
		top_bit   = 1'b0;
		nzcv_next = nzcv_q;
		res.status = ST_OK;
		unique case (dec.kind)
			KIND_ADDSUB: begin
				value     = as_res;
				wr_en     = 1'b1;
				set_flags = dec.opc[0];
				top_bit   = dec.sf ? as_res[XLEN-1] : as_res[31];
				if (set_flags) begin
					nzcv_next = {top_bit, as_res == '0, as_c, as_v};
				end
			end
			KIND_LOGIC: begin
				value     = lg_res;
				wr_en     = 1'b1;
				set_flags = (dec.opc == OPC_ANDS);
				top_bit   = dec.sf ? lg_res[XLEN-1] : lg_res[31];
				if (set_flags) begin
					nzcv_next = {top_bit, lg_res == '0, 2'b00};
				end
			end
			KIND_UNDEF: begin
				res.status = ST_UNDEF;
			end
			default: begin
				res.status = ST_UNIMP;
			end
		endcase
		res.rd    = dec.rd;
		res.value = value;
		res.nzcv  = nzcv_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nzcv_q <= '0;
			for (int i = 0; i < NUM_REGS; i++) begin
				gpr_q[i] <= '0;
			end
		end else if (fire) begin
			nzcv_q <= nzcv_next;
			if (wr_en) begin
				gpr_q[dec.rd] <= value;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/aarch64_dp_immediate_execute.sv -----
// An accepted item waits in the decode queue; its result is written into the result
// queue, whose head drives the output ports.
// Throughput: 1 item per cycle unless the result queue is full; the back end reads,
// executes and writes registers and flags at once; dependent items go back to back.
// Reset: arst_n clears both queues, all 32 registers and the NZCV flags at once.
// QUEUE_DEPTH must be 2 or more.
// ----------------------------------------------------------------------------
// aarch64_dp_immediate_execute
// Decodes and executes data-processing-immediate instructions through a
// front end, a decode queue, an execute back end and a result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module aarch64_dp_immediate_execute #(
	parameter int QUEUE_DEPTH = dpi_pkg::DEPTH_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [31:0] instr,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       status,
	output logic [4:0]       dest_reg,
	output logic [63:0]      dest_value,
	output logic             flag_n,
	output logic             flag_z,
	output logic             flag_c,
	output logic             flag_v
);

	import dpi_pkg::*;

	dec_t dec_in;
	dec_t dec_head;
	logic dec_empty;
	logic dec_pop;
	res_t res_in;
	res_t res_head;
	logic res_full;
	logic res_push;

	dpi_front u_front (
		.instr (instr),
		.dec   (dec_in)
	);

	dpi_queue #(
		.item_t (dec_t),
		.DEPTH  (QUEUE_DEPTH)
	) u_dec_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (dec_in),
		.full      (full),
		.pop       (dec_pop),
		.pop_data  (dec_head),
		.empty     (dec_empty)
	);

	dpi_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.dec       (dec_head),
		.dec_empty (dec_empty),
		.dec_pop   (dec_pop),
		.res       (res_in),
		.res_full  (res_full),
		.res_push  (res_push)
	);

	dpi_queue #(
		.item_t (res_t),
		.DEPTH  (QUEUE_DEPTH)
	) u_res_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res_in),
		.full      (res_full),
		.pop       (pop),
		.pop_data  (res_head),
		.empty     (empty)
	);

	assign status     = res_head.status;
	assign dest_reg   = res_head.rd;
	assign dest_value = res_head.value;
	assign flag_n     = res_head.nzcv[3];
	assign flag_z     = res_head.nzcv[2];
	assign flag_c     = res_head.nzcv[1];
	assign flag_v     = res_head.nzcv[0];

endmodule

`default_nettype wire

// ----- bench/tb_aarch64_dp_immediate_execute.sv -----
// ----------------------------------------------------------------------------
// tb_aarch64_dp_immediate_execute
// Self-checking bench for the data-processing-immediate execute block. It
// runs a directed table, then random instruction words. It keeps its own copy
// of the register file and NZCV flags and checks every popped result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_aarch64_dp_immediate_execute;
	timeunit 1ns;
	timeprecision 1ps;

	import dpi_pkg::*;

	// Instruction classes by bits 25..23
	localparam logic [2:0] OP0_PCREL0 = 3'd0;
	localparam logic [2:0] OP0_PCREL1 = 3'd1;
	localparam logic [2:0] OP0_ADDSUB = 3'd2;
	localparam logic [2:0] OP0_TAGS   = 3'd3;
	localparam logic [2:0] OP0_LOGIC  = 3'd4;
	localparam logic [2:0] OP0_MOVW   = 3'd5;
	localparam logic [2:0] OP0_BITF   = 3'd6;
	localparam logic [2:0] OP0_EXTR   = 3'd7;

	localparam int RANDOM_ITEMS = 1450;

	typedef struct packed {
		logic [31:0] word;
		logic        has_want;
		res_t        want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        pop = 1'b0;
	logic [31:0] instr = '0;
	logic        full;
	logic        empty;
	logic [1:0]  status;
	logic [4:0]  dest_reg;
	logic [63:0] dest_value;
	logic        flag_n;
	logic        flag_z;
	logic        flag_c;
	logic        flag_v;

	logic [63:0] gpr_model [NUM_REGS];
	logic [3:0]  nzcv_model = '0;
	res_t        result_q [$];
	dir_row_t    dir_rows [$];
	bit          burst = 1'b0;
	int          mismatch_cnt = 0;

	aarch64_dp_immediate_execute i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.instr      (instr),
		.empty      (empty),
		.pop        (pop),
		.status     (status),
		.dest_reg   (dest_reg),
		.dest_value (dest_value),
		.flag_n     (flag_n),
		.flag_z     (flag_z),
		.flag_c     (flag_c),
		.flag_v     (flag_v)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [31:0] enc_word(input logic sf, input logic [1:0] op,
			input logic [2:0] op0, input logic [22:0] low);
		return {sf, op, 3'b100, op0, low};
	endfunction

	function automatic logic [31:0] enc_add(input logic sf, sub, setf, sh,
			input logic [11:0] imm12, input logic [4:0] rn, rd);
		return enc_word(sf, {sub, setf}, OP0_ADDSUB, {sh, imm12, rn, rd});
	endfunction

	function automatic logic [31:0] enc_log(input logic sf, input logic [1:0] opc,
			input logic nbit, input logic [5:0] immr, imms, input logic [4:0] rn, rd);
		return enc_word(sf, opc, OP0_LOGIC, {nbit, immr, imms, rn, rd});
	endfunction

	// Execute one word against the bench copy of registers and flags.
	function automatic res_t dp_imm_exec(input logic [31:0] w);
		res_t        r;
		logic [4:0]  rd;
		logic [4:0]  rn;
		logic [5:0]  imms;
		logic [5:0]  immr;
		logic [6:0]  sel;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] imm;
		logic [63:0] elem;
		logic [63:0] emask;
		logic [63:0] val;
		logic [64:0] sum;
		logic [32:0] sum32;
		logic        sub;
		logic        nf;
		logic        cf;
		logic        vf;
		int          len;
		int          esize;
		int          lev;
		int          s;
		int          rot;
		int          i;
		r = '0;
		rd = w[4:0];
		rn = w[9:5];
		r.rd = rd;
		r.status = ST_UNIMP;
		if (w[25:23] == OP0_ADDSUB) begin
			sub = w[30];
			imm = {52'd0, w[21:10]};
			if (w[22]) imm = imm << 12;
			b = sub ? ~imm : imm;
			a = gpr_model[rn];
			if (w[31]) begin
				sum = {1'b0, a} + {1'b0, b} + sub;
				val = sum[63:0];
				cf = sum[64];
				nf = val[63];
				vf = (a[63] == b[63]) && (val[63] != a[63]);
			end else begin
				sum32 = {1'b0, a[31:0]} + {1'b0, b[31:0]} + sub;
				val = {32'd0, sum32[31:0]};
				cf = sum32[32];
				nf = val[31];
				vf = (a[31] == b[31]) && (val[31] != a[31]);
			end
			if (w[29]) nzcv_model = {nf, val == 64'd0, cf, vf};
			gpr_model[rd] = val;
			r.status = ST_OK;
			r.value = val;
		end else if (w[25:23] == OP0_LOGIC) begin
			r.status = ST_UNDEF;
			imms = w[15:10];
			immr = w[21:16];
			sel = {w[22], ~imms};
			len = -1;
			for (i = 0; i < 7; i++)
				if (sel[i]) len = i;
			if (!(!w[31] && w[22]) && len >= 1) begin
				esize = 1 << len;
				lev = esize - 1;
				s = imms & lev;
				rot = immr & lev;
				// an all-ones element is reserved
				if (s != lev) begin
					emask = (esize == 64) ? '1 : ((64'd1 << esize) - 64'd1);
					elem = (64'd1 << (s + 1)) - 64'd1;
					if (rot != 0)
						elem = ((elem >> rot) | (elem << (esize - rot))) & emask;
					for (i = esize; i < 64; i = i * 2)
						elem = elem | (elem << i);
					a = gpr_model[rn];
					case (w[30:29])
						OPC_ORR: val = a | elem;
						OPC_EOR: val = a ^ elem;
						default: val = a & elem;
					endcase
					if (!w[31]) val[63:32] = '0;
					if (w[30:29] == OPC_ANDS)
						nzcv_model = {w[31] ? val[63] : val[31], val == 64'd0, 2'b00};
					gpr_model[rd] = val;
					r.status = ST_OK;
					r.value = val;
				end
			end
		end
		r.nzcv = nzcv_model;
		return r;
	endfunction

	// Favor a few low registers so that dependent items chain often.
	function automatic logic [4:0] rand_reg();
		return ($urandom_range(1) == 0) ? 5'($urandom_range(7)) : 5'($urandom_range(31));
	endfunction

	function automatic logic [31:0] rand_instr();
		int   pick;
		logic sf;
		pick = $urandom_range(99);
		sf = 1'($urandom_range(1));
		if (pick < 42)
			return enc_add(sf, 1'($urandom_range(1)), 1'($urandom_range(1)),
				1'($urandom_range(1)),
				($urandom_range(7) == 0) ? 12'hfff : 12'($urandom_range(4095)),
				rand_reg(), rand_reg());
		if (pick < 84)
			return enc_log(sf, 2'($urandom_range(3)),
				sf ? 1'($urandom_range(1)) : ($urandom_range(15) == 0),
				6'($urandom_range(63)), 6'($urandom_range(63)), rand_reg(), rand_reg());
		return $urandom;
	endfunction

	task automatic add_row(input logic [31:0] w, input logic has_want, input res_t want);
		dir_rows.push_back({w, has_want, want});
	endtask

	task automatic send_item(input logic [31:0] w, input logic has_want, input res_t want);
		res_t pred;
		while (!burst && $urandom_range(99) < 29) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		instr <= w;
		@(posedge clk);
		while (full) @(posedge clk);
		pred = dp_imm_exec(w);
		result_q.push_back(has_want ? want : pred);
	endtask

	function automatic void field_chk(input string name, input logic [63:0] expv, actv);
		if (actv !== expv) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, expv, actv);
			mismatch_cnt++;
		end
	endfunction

	task automatic check_result();
		res_t want;
		if (result_q.size() == 0) begin
			$error("result with no item pending: dest_reg %0d", dest_reg);
			mismatch_cnt++;
		end else begin
			want = result_q.pop_front();
			field_chk("status", 64'(want.status), 64'(status));
			field_chk("dest_reg", 64'(want.rd), 64'(dest_reg));
			field_chk("dest_value", want.value, dest_value);
			field_chk("flag_n", 64'(want.nzcv[3]), 64'(flag_n));
			field_chk("flag_z", 64'(want.nzcv[2]), 64'(flag_z));
			field_chk("flag_c", 64'(want.nzcv[1]), 64'(flag_c));
			field_chk("flag_v", 64'(want.nzcv[0]), 64'(flag_v));
		end
	endtask

	initial begin
		wait (arst_n === 1'b1);
		forever begin
			pop <= burst || ($urandom_range(99) >= 29);
			@(posedge clk);
			if (pop && !empty) check_result();
		end
	end

	initial begin
		int k;
		for (k = 0; k < NUM_REGS; k++) gpr_model[k] = '0;

		// Known results straight out of reset: registers and flags all zero.
		add_row(enc_add(1, 0, 0, 0, 12'h000, 5'd0, 5'd0), 1, {ST_OK, 5'd0, 64'd0, 4'b0000});
		add_row(enc_add(1, 0, 0, 0, 12'hfff, 5'd31, 5'd5), 1,
			{ST_OK, 5'd5, 64'h0fff, 4'b0000});
		add_row(enc_word(1, 2'b11, OP0_PCREL0, 23'h7fffe1), 1, {ST_UNIMP, 5'd1, 64'd0, 4'b0000});
		add_row(enc_word(0, 2'b00, OP0_PCREL1, 23'h000002), 1, {ST_UNIMP, 5'd2, 64'd0, 4'b0000});
		add_row(enc_word(1, 2'b01, OP0_TAGS, 23'h123443), 1, {ST_UNIMP, 5'd3, 64'd0, 4'b0000});
		add_row(enc_word(0, 2'b10, OP0_MOVW, 23'h7fff04), 1, {ST_UNIMP, 5'd4, 64'd0, 4'b0000});
		add_row(enc_word(1, 2'b11, OP0_BITF, 23'h000025), 1, {ST_UNIMP, 5'd5, 64'd0, 4'b0000});
		add_row(enc_word(1, 2'b00, OP0_EXTR, 23'h555546), 1, {ST_UNIMP, 5'd6, 64'd0, 4'b0000});
		// 32-bit form with N set
		add_row(enc_log(0, OPC_AND, 1, 6'h00, 6'h00, 5'd5, 5'd7), 1,
			{ST_UNDEF, 5'd7, 64'd0, 4'b0000});
		// no element size
		add_row(enc_log(1, OPC_ORR, 0, 6'h00, 6'h3f, 5'd5, 5'd8), 1,
			{ST_UNDEF, 5'd8, 64'd0, 4'b0000});
		// all-ones element at 64, 32 and 2 bits
		add_row(enc_log(1, OPC_EOR, 1, 6'h3f, 6'h3f, 5'd5, 5'd9), 1,
			{ST_UNDEF, 5'd9, 64'd0, 4'b0000});
		add_row(enc_log(0, OPC_ANDS, 0, 6'h01, 6'h1f, 5'd5, 5'd10), 1,
			{ST_UNDEF, 5'd10, 64'd0, 4'b0000});
		add_row(enc_log(1, OPC_AND, 0, 6'h00, 6'h3d, 5'd5, 5'd11), 1,
			{ST_UNDEF, 5'd11, 64'd0, 4'b0000});
		add_row(enc_log(1, OPC_ORR, 0, 6'h00, 6'h3c, 5'd0, 5'd7), 1,
			{ST_OK, 5'd7, 64'h5555555555555555, 4'b0000});
		add_row(enc_add(0, 1, 1, 0, 12'h001, 5'd0, 5'd2), 1,
			{ST_OK, 5'd2, 64'h00000000ffffffff, 4'b1000});
		// Flag corners and register 31, checked by the predictor.
		add_row(enc_log(1, OPC_ORR, 1, 6'h00, 6'h3e, 5'd31, 5'd9), 0, '0);
		add_row(enc_add(1, 0, 1, 0, 12'h001, 5'd9, 5'd10), 0, '0);
		add_row(enc_log(1, OPC_EOR, 1, 6'h01, 6'h00, 5'd9, 5'd11), 0, '0);
		add_row(enc_add(1, 0, 1, 0, 12'h001, 5'd11, 5'd12), 0, '0);
		add_row(enc_add(1, 1, 1, 0, 12'h000, 5'd12, 5'd13), 0, '0);
		add_row(enc_log(1, OPC_ANDS, 1, 6'h01, 6'h00, 5'd11, 5'd14), 0, '0);
		add_row(enc_log(0, OPC_ANDS, 0, 6'h01, 6'h1e, 5'd11, 5'd15), 0, '0);
		add_row(enc_add(0, 0, 1, 0, 12'h001, 5'd11, 5'd16), 0, '0);
		add_row(enc_add(1, 1, 1, 1, 12'hfff, 5'd9, 5'd18), 0, '0);
		add_row(enc_add(1, 0, 0, 0, 12'h001, 5'd5, 5'd31), 0, '0);
		add_row(enc_log(1, OPC_AND, 0, 6'h05, 6'h07, 5'd31, 5'd19), 0, '0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[j])
			send_item(dir_rows[j].word, dir_rows[j].has_want, dir_rows[j].want);

		for (k = 0; k < RANDOM_ITEMS; k++) begin
			// hold both sides busy through the middle stretch
			burst = (k >= 500 && k < 800);
			send_item(rand_instr(), 1'b0, '0);
		end
		burst = 1'b0;
		push <= 1'b0;

		while (result_q.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
